>>> rtl/wtm_pkg.sv
// Shared types, character codes and sizes for the web text minifier.
package wtm_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [1:0] kind_type;
   typedef logic [1:0] code_type;

   // byte window: three behind, the current byte, five ahead
   localparam int WinSize = 9;
   localparam int WinCur  = 3;
   typedef byte_type [WinSize-1:0] win_type;

   // undecided bytes held in the current and ahead slots
   localparam int FillW = 4;
   localparam logic [FillW-1:0] FillMax = FillW'(WinSize - WinCur);
   localparam int PadW = 3;

   // output queue
   localparam int FifoDepth = 4;
   localparam int PushMax   = 3;
   localparam int PtrW      = $clog2(FifoDepth);
   localparam int CntW      = $clog2(FifoDepth + 1);
   localparam int PushCntW  = $clog2(PushMax + 1);

   localparam byte_type StartByte = 8'h78;
   localparam byte_type PadByte   = 8'hFF;

   localparam byte_type ChBackslash = 8'h5C;
   localparam byte_type ChNewline   = 8'h0A;
   localparam byte_type ChTab       = 8'h09;
   localparam byte_type ChSpace     = 8'h20;
   localparam byte_type ChDquote    = 8'h22;
   localparam byte_type ChSquote    = 8'h27;
   localparam byte_type ChLt        = 8'h3C;
   localparam byte_type ChGt        = 8'h3E;
   localparam byte_type ChBang      = 8'h21;
   localparam byte_type ChDash      = 8'h2D;
   localparam byte_type ChStar      = 8'h2A;
   localparam byte_type ChSlash     = 8'h2F;
   localparam byte_type ChDollar    = 8'h24;
   localparam byte_type ChUnder     = 8'h5F;
   localparam byte_type ChPercent   = 8'h25;
   localparam byte_type ChHash      = 8'h23;
   localparam byte_type ChDot       = 8'h2E;
   localparam byte_type ChPlus      = 8'h2B;
   localparam byte_type ChLowP      = 8'h70;
   localparam byte_type ChLowR      = 8'h72;
   localparam byte_type ChLowE      = 8'h65;

   localparam kind_type KindHtml = 2'd0;
   localparam kind_type KindCss  = 2'd1;
   localparam kind_type KindJs   = 2'd2;
   localparam kind_type KindJson = 2'd3;

   localparam code_type QuoteNone   = 2'd0;
   localparam code_type QuoteDouble = 2'd1;
   localparam code_type QuoteSingle = 2'd2;
   localparam code_type QuotePre    = 2'd3;

   localparam code_type CommentNone  = 2'd0;
   localparam code_type CommentBlock = 2'd1;
   localparam code_type CommentLine  = 2'd2;
   localparam code_type CommentHtml  = 2'd3;

   typedef struct packed {
      code_type quote;
      code_type comment;
      byte_type last_nonspace;
   } ctx_type;

   typedef struct packed {
      logic [1:0] count;
      byte_type   first;
      byte_type   second;
      ctx_type    ctx;
   } dec_type;

   typedef struct packed {
      byte_type out_byte;
      logic     has_byte;
      logic     stream_end;
   } res_type;

   typedef struct packed {
      logic [PushCntW-1:0]       count;
      res_type [PushMax-1:0]     data;
   } push_type;

endpackage

>>> rtl/wtm_decide.sv
// Per-byte decision: quote and comment tracking and keep or drop of the current byte.
module wtm_decide (
   input  wtm_pkg::win_type  win,
   input  wtm_pkg::kind_type kind,
   input  wtm_pkg::ctx_type  ctx,
   output wtm_pkg::dec_type  dec
);

   function automatic logic is_name(input wtm_pkg::kind_type k, input wtm_pkg::byte_type ch);
      logic alnum;
      logic res;
      alnum = (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A) ||
              (ch >= 8'h30 && ch <= 8'h39);
      case (k)
         wtm_pkg::KindHtml: begin
            res = ch != wtm_pkg::ChSpace && ch != wtm_pkg::ChGt;
         end
         wtm_pkg::KindCss: begin
            res = alnum || ch == wtm_pkg::ChDollar || ch == wtm_pkg::ChUnder ||
                  ch == wtm_pkg::ChHash || ch == wtm_pkg::ChDot || ch == wtm_pkg::ChPlus ||
                  ch == wtm_pkg::ChDash || ch == wtm_pkg::ChPercent || ch == wtm_pkg::ChStar;
         end
         default: begin
            res = alnum || ch == wtm_pkg::ChDollar || ch == wtm_pkg::ChUnder;
         end
      endcase
      return res;
   endfunction

   wtm_pkg::byte_type cur;
   wtm_pkg::byte_type back1, back2, back3;
   wtm_pkg::byte_type next1, next2, next3, next4, next5;
   logic              html;
   logic              unesc;
   logic              pre_tag;
   logic              block_end;
   wtm_pkg::code_type quote_chk;
   logic              bslash_chk;
   wtm_pkg::code_type comment_chk;
   logic              no_comment;
   logic              in_quote;
   logic              bslash;
   logic              emit_cur;

   assign cur   = win[wtm_pkg::WinCur];
   assign back1 = win[wtm_pkg::WinCur-1];
   assign back2 = win[wtm_pkg::WinCur-2];
   assign back3 = win[wtm_pkg::WinCur-3];
   assign next1 = win[wtm_pkg::WinCur+1];
   assign next2 = win[wtm_pkg::WinCur+2];
   assign next3 = win[wtm_pkg::WinCur+3];
   assign next4 = win[wtm_pkg::WinCur+4];
   assign next5 = win[wtm_pkg::WinCur+5];

   assign html  = kind == wtm_pkg::KindHtml;
   assign unesc = back1 != wtm_pkg::ChBackslash;

   // <pre>, </pre> and the like
   assign pre_tag = cur == wtm_pkg::ChLt &&
                    (next1 == wtm_pkg::ChLowP || next1 == wtm_pkg::ChSlash) &&
                    (next2 == wtm_pkg::ChLowR || next2 == wtm_pkg::ChLowP) &&
                    (next3 == wtm_pkg::ChLowE || next3 == wtm_pkg::ChLowR) &&
                    (next4 == wtm_pkg::ChGt ||
                     (next4 == wtm_pkg::ChLowE && next5 == wtm_pkg::ChGt));

   assign block_end = html ?
      (back1 == wtm_pkg::ChSlash && back2 == wtm_pkg::ChStar && back3 != wtm_pkg::ChSlash) :
      (back2 == wtm_pkg::ChStar && back1 == wtm_pkg::ChSlash);

   always_comb begin
      quote_chk  = ctx.quote;
      bslash_chk = 1'b0;
      if (cur == wtm_pkg::ChDquote && unesc) begin
         if (ctx.quote == wtm_pkg::QuoteNone) quote_chk = wtm_pkg::QuoteDouble;
         else if (ctx.quote == wtm_pkg::QuoteDouble) quote_chk = wtm_pkg::QuoteNone;
      end else if (cur == wtm_pkg::ChSquote && unesc) begin
         if (kind == wtm_pkg::KindJson) bslash_chk = 1'b1;
         else if (ctx.quote == wtm_pkg::QuoteNone) quote_chk = wtm_pkg::QuoteSingle;
         else if (ctx.quote == wtm_pkg::QuoteSingle) quote_chk = wtm_pkg::QuoteNone;
      end else if (html && pre_tag) begin
         if (ctx.quote == wtm_pkg::QuoteNone) quote_chk = wtm_pkg::QuotePre;
         else if (ctx.quote == wtm_pkg::QuotePre) quote_chk = wtm_pkg::QuoteNone;
      end
   end

   always_comb begin
      comment_chk = ctx.comment;
      if (cur == wtm_pkg::ChSlash && next1 == wtm_pkg::ChStar &&
          ctx.comment == wtm_pkg::CommentNone) begin
         comment_chk = wtm_pkg::CommentBlock;
      end else if (block_end && ctx.comment == wtm_pkg::CommentBlock) begin
         comment_chk = wtm_pkg::CommentNone;
      end else if (cur == wtm_pkg::ChSlash && next1 == wtm_pkg::ChSlash &&
                   ctx.comment == wtm_pkg::CommentNone) begin
         comment_chk = wtm_pkg::CommentLine;
      end else if (back1 == wtm_pkg::ChNewline && ctx.comment == wtm_pkg::CommentLine) begin
         comment_chk = wtm_pkg::CommentNone;
      end else if (html && cur == wtm_pkg::ChLt && next1 == wtm_pkg::ChBang &&
                   next2 == wtm_pkg::ChDash && next3 == wtm_pkg::ChDash &&
                   ctx.comment == wtm_pkg::CommentNone) begin
         comment_chk = wtm_pkg::CommentHtml;
      end else if (html && back3 == wtm_pkg::ChDash && back2 == wtm_pkg::ChDash &&
                   back1 == wtm_pkg::ChGt && ctx.comment == wtm_pkg::CommentHtml) begin
         comment_chk = wtm_pkg::CommentNone;
      end
   end

   // quote tracking only runs outside comments
   assign no_comment = ctx.comment == wtm_pkg::CommentNone;
   assign in_quote   = no_comment && quote_chk != wtm_pkg::QuoteNone;
   assign bslash     = no_comment && bslash_chk;

   always_comb begin
      dec.ctx.quote         = no_comment ? quote_chk : ctx.quote;
      dec.ctx.comment       = ctx.comment;
      dec.ctx.last_nonspace = ctx.last_nonspace;
      emit_cur              = 1'b0;
      if (in_quote) begin
         emit_cur = 1'b1;
      end else begin
         dec.ctx.comment = comment_chk;
         if (comment_chk != wtm_pkg::CommentNone || cur == wtm_pkg::ChNewline ||
             cur == wtm_pkg::ChTab) begin
            emit_cur = 1'b0;
         end else if (cur != wtm_pkg::ChSpace) begin
            dec.ctx.last_nonspace = cur;
            emit_cur              = 1'b1;
         end else begin
            // keep a space only between two name characters
            emit_cur = is_name(kind, next1) && is_name(kind, ctx.last_nonspace);
         end
      end

      if (bslash) begin
         dec.first  = wtm_pkg::ChBackslash;
         dec.second = cur;
         dec.count  = emit_cur ? 2'd2 : 2'd1;
      end else begin
         dec.first  = cur;
         dec.second = cur;
         dec.count  = emit_cur ? 2'd1 : 2'd0;
      end
   end

endmodule

>>> rtl/wtm_out_fifo.sv
// Result queue: takes up to three beats a cycle, hands out one beat a cycle while the head is not stalled.
module wtm_out_fifo (
   input  logic              clock,
   input  logic              reset,
   input  wtm_pkg::push_type push,
   output logic              room,
   output wtm_pkg::res_type  head,
   output logic              head_valid,
   input  logic              head_stall
);

   wtm_pkg::res_type              entry_ff [wtm_pkg::FifoDepth];
   logic [wtm_pkg::PtrW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [wtm_pkg::PtrW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [wtm_pkg::CntW-1:0]      count_ff, count_in;
   logic [wtm_pkg::PtrW-1:0]      wr_addr [wtm_pkg::PushMax];
   logic                          pop;

   assign head_valid = count_ff != '0;
   assign head       = entry_ff[rd_ptr_ff];
   assign pop        = head_valid && !head_stall;
   // room for a full push regardless of what leaves this cycle
   assign room       = count_ff <= wtm_pkg::CntW'(wtm_pkg::FifoDepth - wtm_pkg::PushMax);

   always_comb begin
      for (int i = 0; i < wtm_pkg::PushMax; i++) begin
         wr_addr[i] = wr_ptr_ff + wtm_pkg::PtrW'(i);
      end
      wr_ptr_in = wr_ptr_ff + wtm_pkg::PtrW'(push.count);
      rd_ptr_in = rd_ptr_ff + wtm_pkg::PtrW'(pop);
      count_in  = count_ff + wtm_pkg::CntW'(push.count) - wtm_pkg::CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < wtm_pkg::PushMax; i++) begin
         if (wtm_pkg::PushCntW'(i) < push.count) begin
            entry_ff[wr_addr[i]] <= push.data[i];
         end
      end
   end

endmodule

>>> rtl/web_text_minifier.sv
// Top level of the streaming web text minifier.
// Usage:
//   req_* carries one source byte per beat; req_in_last marks the final byte of
//   a text. rsp_* carries one minified byte per beat; rsp_has_byte is 0 only on
//   a bare end marker, rsp_stream_end flags the final beat of a text.
//   csr_write_en/csr_write_data set the text kind (0 html, 1 css, 2 js, 3 json);
//   write it only while the block is idle.
// Timing:
//   A byte is decided once five later bytes have arrived. Each accepted beat is
//   registered in the input register, decided from there and written to the
//   output queue, whose head drives rsp. One source byte per cycle is
//   sustained while the queue has room; a json single quote yields two result
//   beats. After the last byte the window drains on pad bytes, with at
//   most one decision per cycle, during which no new byte is taken.
//   A stalled rsp holds its beat; once the four-entry queue holds two or more
//   beats, no byte is decided and req_stall rises when the input register is full.
// Reset:
//   Synchronous reset empties the queue, clears quote and comment tracking,
//   refills the window with 'x' and sets the kind to js.
module web_text_minifier (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_has_byte,
   output logic       rsp_stream_end,
   input  logic       csr_write_en,
   input  logic [1:0] csr_write_data
);

   wtm_pkg::kind_type              kind_ff, kind_in;
   logic                           in_valid_ff, in_valid_in;
   wtm_pkg::byte_type              in_byte_ff;
   logic                           in_last_ff;
   wtm_pkg::win_type               win_ff, win_in;
   logic [wtm_pkg::FillW-1:0]      fill_ff, fill_in;
   logic [wtm_pkg::PadW-1:0]       pad_ff, pad_in;
   logic                           flush_ff, flush_in;
   wtm_pkg::ctx_type               ctx_ff, ctx_in;
   logic                           held_valid_ff, held_valid_in;
   wtm_pkg::byte_type              held_byte_ff, held_byte_in;

   wtm_pkg::win_type               shifted;
   wtm_pkg::win_type               padded;
   wtm_pkg::win_type               dec_win;
   wtm_pkg::dec_type               dec;
   wtm_pkg::push_type              push;
   wtm_pkg::res_type               head;
   logic                           room;
   logic                           req_accept;
   logic                           take;
   logic                           step_flush;
   logic [wtm_pkg::FillW-1:0]      fill_inc;
   logic [wtm_pkg::FillW-1:0]      pad_sum;
   logic                           take_dec;
   logic                           flush_dec;
   logic                           dec_valid;
   logic                           final_step;
   logic [1:0]                     new_n;
   logic                           hold_back;
   logic [wtm_pkg::PushMax-1:0]    cand_v;
   wtm_pkg::byte_type              cand_b [wtm_pkg::PushMax];
   logic [wtm_pkg::PushCntW-1:0]   k;

   assign take       = in_valid_ff && !flush_ff && room;
   assign step_flush = flush_ff && room;
   assign req_stall  = in_valid_ff && !take;
   assign req_accept = req_valid && !req_stall;

   assign fill_inc  = (fill_ff < wtm_pkg::FillMax) ? fill_ff + 1'b1 : fill_ff;
   assign pad_sum   = fill_ff + wtm_pkg::FillW'(pad_ff);
   assign take_dec  = !in_last_ff && fill_inc == wtm_pkg::FillMax;
   assign flush_dec = pad_sum >= wtm_pkg::FillMax;
   assign dec_valid = take ? take_dec : (step_flush && flush_dec);
   assign final_step = step_flush && flush_dec && fill_ff == wtm_pkg::FillW'(1);

   always_comb begin
      for (int i = 0; i < wtm_pkg::WinSize - 1; i++) begin
         shifted[i] = win_ff[i+1];
         padded[i]  = win_ff[i+1];
      end
      shifted[wtm_pkg::WinSize-1] = in_byte_ff;
      padded[wtm_pkg::WinSize-1]  = wtm_pkg::PadByte;
   end

   assign dec_win = take ? shifted : win_ff;

   wtm_decide u_decide (
      .win  (dec_win),
      .kind (kind_ff),
      .ctx  (ctx_ff),
      .dec  (dec)
   );

   // During a drain the newest result is held back so the end flag can land on it.
   always_comb begin
      new_n     = dec_valid ? dec.count : 2'd0;
      hold_back = step_flush && !final_step && new_n != 2'd0;

      cand_v[0] = step_flush && held_valid_ff && (final_step || new_n != 2'd0);
      cand_v[1] = new_n != 2'd0 && !(hold_back && new_n == 2'd1);
      cand_v[2] = new_n == 2'd2 && !hold_back;
      cand_b[0] = held_byte_ff;
      cand_b[1] = dec.first;
      cand_b[2] = dec.second;

      push.data = '0;
      k         = '0;
      for (int i = 0; i < wtm_pkg::PushMax; i++) begin
         if (cand_v[i]) begin
            push.data[k[1:0]].out_byte   = cand_b[i];
            push.data[k[1:0]].has_byte   = 1'b1;
            push.data[k[1:0]].stream_end = 1'b0;
            k = k + 1'b1;
         end
      end
      if (final_step) begin
         if (k == '0) begin
            push.data[0].out_byte   = '0;
            push.data[0].has_byte   = 1'b0;
            push.data[0].stream_end = 1'b1;
            k = wtm_pkg::PushCntW'(1);
         end else begin
            push.data[k[1:0] - 2'd1].stream_end = 1'b1;
         end
      end
      push.count = k;
   end

   always_comb begin
      kind_in       = csr_write_en ? csr_write_data : kind_ff;
      in_valid_in   = req_accept ? 1'b1 : (take ? 1'b0 : in_valid_ff);
      win_in        = win_ff;
      fill_in       = fill_ff;
      pad_in        = pad_ff;
      flush_in      = flush_ff;
      ctx_in        = dec_valid ? dec.ctx : ctx_ff;
      held_valid_in = held_valid_ff;
      held_byte_in  = held_byte_ff;

      if (take) begin
         win_in = shifted;
         if (in_last_ff) begin
            fill_in  = fill_inc;
            pad_in   = '0;
            flush_in = 1'b1;
         end else begin
            fill_in = take_dec ? wtm_pkg::FillMax - 1'b1 : fill_inc;
         end
      end else if (step_flush) begin
         if (final_step) begin
            // start the next text
            win_in               = {wtm_pkg::WinSize{wtm_pkg::StartByte}};
            fill_in              = '0;
            flush_in             = 1'b0;
            ctx_in.last_nonspace = '0;
         end else begin
            win_in  = padded;
            fill_in = flush_dec ? fill_ff - 1'b1 : fill_ff;
            pad_in  = pad_ff + 1'b1;
         end
      end

      if (final_step) begin
         held_valid_in = 1'b0;
      end else if (hold_back) begin
         held_valid_in = 1'b1;
         held_byte_in  = (new_n == 2'd2) ? dec.second : dec.first;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff       <= wtm_pkg::KindJs;
         in_valid_ff   <= 1'b0;
         win_ff        <= {wtm_pkg::WinSize{wtm_pkg::StartByte}};
         fill_ff       <= '0;
         pad_ff        <= '0;
         flush_ff      <= 1'b0;
         ctx_ff        <= '0;
         held_valid_ff <= 1'b0;
      end else begin
         kind_ff       <= kind_in;
         in_valid_ff   <= in_valid_in;
         win_ff        <= win_in;
         fill_ff       <= fill_in;
         pad_ff        <= pad_in;
         flush_ff      <= flush_in;
         ctx_ff        <= ctx_in;
         held_valid_ff <= held_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_in_last;
      end
      held_byte_ff <= held_byte_in;
   end

   wtm_out_fifo u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .head       (head),
      .head_valid (rsp_valid),
      .head_stall (rsp_stall)
   );

   assign rsp_out_byte   = head.out_byte;
   assign rsp_has_byte   = head.has_byte;
   assign rsp_stream_end = head.stream_end;

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= wtm_pkg::FillMax)
      else $error("window fill count out of range");

   a_drain_pending: assert property (@(posedge clock) disable iff (reset)
      flush_ff |-> fill_ff != '0)
      else $error("drain running with no pending byte");

   a_held_in_drain: assert property (@(posedge clock) disable iff (reset)
      held_valid_ff |-> flush_ff)
      else $error("held result outside a drain");

   a_drain_done: assert property (@(posedge clock) disable iff (reset)
      final_step |=> (fill_ff == '0 && !flush_ff && !held_valid_ff))
      else $error("window not restarted after drain");
`endif

endmodule

>>> bench/testbench.sv
// Self-checking bench for web_text_minifier: byte-stream driver, predictor and result checker.
`timescale 1ns / 100ps

module testbench;
   import wtm_pkg::*;

   localparam int RandomItems = 420;
   localparam int DrainCycles = 24;
   localparam int CycleLimit  = 200000;
   localparam int MaxPerByte  = 12;
   localparam int IdlePercent = 22;

   typedef struct {
      byte_type data;
      logic     last;
   } src_beat;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = '0;
   logic       req_in_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_has_byte;
   logic       rsp_stream_end;
   logic       csr_write_en = 1'b0;
   logic [1:0] csr_write_data = KindJs;

   web_text_minifier uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .req_in_last    (req_in_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_has_byte   (rsp_has_byte),
      .rsp_stream_end (rsp_stream_end),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // stimulus and expectations
   src_beat  source_beats[$];
   res_type  expected_beats[$];
   byte_type text_buf[$];
   int       queued_count = 0;
   int       accepted_count = 0;
   int       beats_checked = 0;
   int       texts_seen = 0;
   int       errors = 0;
   int       cycles = 0;
   logic     req_taken = 1'b0;
   logic     steady = 1'b0;

   // minifier model state
   kind_type kind_now;
   byte_type win_bytes [WinSize];
   int       undecided;
   code_type quote_mode;
   code_type comment_mode;
   byte_type prev_solid;
   byte_type step_out[$];

   function automatic byte_type win_at(int k);
      return win_bytes[WinCur + k];
   endfunction

   function automatic void shift_window(byte_type b);
      for (int i = 0; i < WinSize - 1; i++) win_bytes[i] = win_bytes[i + 1];
      win_bytes[WinSize - 1] = b;
   endfunction

   function automatic void open_text();
      for (int i = 0; i < WinSize; i++) win_bytes[i] = StartByte;
      undecided = 0;
      prev_solid = '0;
   endfunction

   function automatic void emit_byte(byte_type b);
      if (step_out.size() < MaxPerByte) step_out.push_back(b);
   endfunction

   function automatic logic name_char(byte_type c);
      logic alnum;
      alnum = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
      case (kind_now)
         KindHtml: return c != ChSpace && c != ChGt;
         KindCss: return alnum || c == ChDollar || c == ChUnder || c == ChHash ||
                         c == ChDot || c == ChPlus || c == ChDash || c == ChPercent ||
                         c == ChStar;
         default: return alnum || c == ChDollar || c == ChUnder;
      endcase
   endfunction

   function automatic logic pre_tag(byte_type c);
      byte_type a, b, d, e;
      a = win_at(1);
      b = win_at(2);
      d = win_at(3);
      e = win_at(4);
      return c == ChLt && (a == ChLowP || a == ChSlash) && (b == ChLowR || b == ChLowP) &&
             (d == ChLowE || d == ChLowR) && (e == ChGt || (e == ChLowE && win_at(5) == ChGt));
   endfunction

   function automatic code_type track_quote(byte_type c);
      logic unesc;
      unesc = win_at(-1) != ChBackslash;
      if (c == ChDquote && unesc) begin
         if (quote_mode == QuoteNone) quote_mode = QuoteDouble;
         else if (quote_mode == QuoteDouble) quote_mode = QuoteNone;
      end else if (c == ChSquote && unesc) begin
         if (kind_now == KindJson) emit_byte(ChBackslash);
         else if (quote_mode == QuoteNone) quote_mode = QuoteSingle;
         else if (quote_mode == QuoteSingle) quote_mode = QuoteNone;
      end else if (kind_now == KindHtml && pre_tag(c)) begin
         if (quote_mode == QuoteNone) quote_mode = QuotePre;
         else if (quote_mode == QuotePre) quote_mode = QuoteNone;
      end
      return quote_mode;
   endfunction

   function automatic code_type track_comment(byte_type c);
      logic html, block_end;
      html = kind_now == KindHtml;
      block_end = html ? (win_at(-1) == ChSlash && win_at(-2) == ChStar && win_at(-3) != ChSlash)
                       : (win_at(-2) == ChStar && win_at(-1) == ChSlash);
      if (c == ChSlash && win_at(1) == ChStar && comment_mode == CommentNone)
         comment_mode = CommentBlock;
      else if (block_end && comment_mode == CommentBlock)
         comment_mode = CommentNone;
      else if (c == ChSlash && win_at(1) == ChSlash && comment_mode == CommentNone)
         comment_mode = CommentLine;
      else if (win_at(-1) == ChNewline && comment_mode == CommentLine)
         comment_mode = CommentNone;
      else if (html && c == ChLt && win_at(1) == ChBang && win_at(2) == ChDash &&
               win_at(3) == ChDash && comment_mode == CommentNone)
         comment_mode = CommentHtml;
      else if (html && win_at(-3) == ChDash && win_at(-2) == ChDash && win_at(-1) == ChGt &&
               comment_mode == CommentHtml)
         comment_mode = CommentNone;
      return comment_mode;
   endfunction

   function automatic void decide_byte();
      byte_type c;
      c = win_at(0);
      if (comment_mode == CommentNone && track_quote(c) != QuoteNone) begin
         emit_byte(c);
         return;
      end
      if (track_comment(c) != CommentNone || c == ChNewline || c == ChTab) return;
      if (c != ChSpace) prev_solid = c;
      else if (!name_char(win_at(1)) || !name_char(prev_solid)) return;
      emit_byte(c);
   endfunction

   // advance the model by one source byte and queue the beats it yields
   function automatic void minify_step(byte_type b, logic last);
      res_type r;
      step_out.delete();
      shift_window(b);
      if (undecided < 6) undecided++;
      if (!last) begin
         if (undecided >= 6) begin
            decide_byte();
            undecided = 5;
         end
      end else begin
         for (int pad = 0; pad < 12 && undecided > 0; pad++) begin
            if (undecided + pad >= 6) begin
               decide_byte();
               undecided--;
            end
            shift_window(PadByte);
         end
      end
      foreach (step_out[k]) begin
         r.out_byte   = step_out[k];
         r.has_byte   = 1'b1;
         r.stream_end = last && (k == step_out.size() - 1);
         expected_beats.push_back(r);
      end
      if (last) begin
         if (step_out.size() == 0) begin
            r.out_byte   = '0;
            r.has_byte   = 1'b0;
            r.stream_end = 1'b1;
            expected_beats.push_back(r);
         end
         open_text();
      end
   endfunction

   task automatic report_mismatch(string msg);
      errors++;
      $display("mismatch at cycle %0d: %s", cycles, msg);
   endtask

   function automatic logic roll_idle();
      return !steady && ($urandom_range(0, 99) < IdlePercent);
   endfunction

   // drive source beats and the result stall at the falling edge
   always @(negedge clock) begin : drive
      src_beat nxt;
      if (!reset && (!req_valid || req_taken)) begin
         if (source_beats.size() != 0 && !roll_idle()) begin
            nxt = source_beats.pop_front();
            req_valid   <= 1'b1;
            req_in_byte <= nxt.data;
            req_in_last <= nxt.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= roll_idle();
   end

   // sample both channels and the register port at the rising edge
   always @(posedge clock) begin : sample
      res_type want;
      cycles++;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            minify_step(req_in_byte, req_in_last);
            accepted_count++;
         end
         if (csr_write_en) kind_now = csr_write_data;
         if (rsp_valid && !rsp_stall) begin
            beats_checked++;
            if (rsp_stream_end === 1'b1) texts_seen++;
            if (expected_beats.size() == 0) begin
               report_mismatch($sformatf("beat with no expectation, byte %02h", rsp_out_byte));
            end else begin
               want = expected_beats.pop_front();
               if (rsp_out_byte !== want.out_byte)
                  report_mismatch($sformatf("out_byte %02h, want %02h",
                                            rsp_out_byte, want.out_byte));
               if (rsp_has_byte !== want.has_byte)
                  report_mismatch($sformatf("has_byte %b, want %b", rsp_has_byte, want.has_byte));
               if (rsp_stream_end !== want.stream_end)
                  report_mismatch($sformatf("stream_end %b, want %b",
                                            rsp_stream_end, want.stream_end));
            end
         end
      end
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles, %0d beats still expected",
                  cycles, expected_beats.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic add_item(byte_type b, logic last);
      src_beat s;
      s.data = b;
      s.last = last;
      source_beats.push_back(s);
      queued_count++;
   endtask

   task automatic add_text(string s, logic close);
      for (int i = 0; i < s.len(); i++) add_item(s[i], close && (i == s.len() - 1));
   endtask

   function automatic void add_chars(string s);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
   endfunction

   function automatic void add_word();
      string pool;
      pool = "abcxyzAZ09$_#.+-%*";
      repeat ($urandom_range(1, 4)) text_buf.push_back(pool[$urandom_range(0, pool.len() - 1)]);
   endfunction

   // mostly well-formed constructs with random content; the rest noise and broken ones
   function automatic void add_fragment();
      string punct, broken [7];
      punct = "{}();:,=<>!*/-";
      broken = '{"/*", "<!-", "<pr", "*/", "-->", "</pre", "\""};
      case ($urandom_range(0, 15))
         0, 1: add_word();
         2: repeat ($urandom_range(1, 3)) text_buf.push_back(ChSpace);
         3: text_buf.push_back($urandom_range(0, 1) ? ChNewline : ChTab);
         4: begin
            add_chars("\""); add_word(); add_chars(" "); add_word();
            if ($urandom_range(0, 1)) add_chars("\\\"");
            add_chars("\"");
         end
         5: begin
            add_chars("'"); add_word(); add_chars(" "); add_word();
            if ($urandom_range(0, 1)) add_chars("\\'");
            add_chars("'");
         end
         6: begin
            add_chars("/*"); add_word(); add_chars(" "); add_word(); add_chars("*/");
         end
         7: begin
            add_chars("//"); add_word(); add_chars(" "); add_word(); add_chars("\n");
         end
         8: begin
            add_chars("<!--"); add_word(); add_chars("-->");
         end
         9: begin
            add_chars("<pre>"); add_word(); add_chars("  \n"); add_word(); add_chars("</pre>");
         end
         10: add_chars($urandom_range(0, 1) ? "\\'" : "\\\"");
         11: text_buf.push_back(punct[$urandom_range(0, punct.len() - 1)]);
         12: text_buf.push_back(byte_type'($urandom_range(0, 255)));
         13: text_buf.push_back(PadByte);
         14: add_chars(broken[$urandom_range(0, 6)]);
         default: begin
            add_word(); add_chars(" "); add_word();
         end
      endcase
   endfunction

   task automatic queue_text(logic close);
      text_buf.delete();
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6))
         add_fragment();
      foreach (text_buf[i]) add_item(text_buf[i], close && (i == text_buf.size() - 1));
   endtask

   task automatic write_kind(kind_type k);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= k;
      @(negedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // wait until every source beat is taken and every result has come back
   task automatic drain();
      while (accepted_count != queued_count || expected_beats.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   initial begin : stimulus
      kind_type kind_order [4];
      int phase;
      int directed;
      kind_order = '{KindHtml, KindJson, KindCss, KindJs};
      kind_now = KindJs;
      quote_mode = QuoteNone;
      comment_mode = CommentNone;
      open_text();
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // js at reset kind: space between names kept, newline dropped
      add_text("a b\n", 1'b1);
      // nothing survives: bare end marker
      add_text("\n", 1'b1);
      add_item(8'h00, 1'b1);
      add_item(PadByte, 1'b1);
      drain();
      write_kind(KindJson);
      add_text("'a'", 1'b1);
      drain();
      write_kind(KindCss);
      add_text("a% b", 1'b1);
      drain();
      write_kind(KindHtml);
      add_text("<!--x-->y", 1'b1);
      drain();
      directed = queued_count;

      phase = 0;
      while (queued_count < directed + RandomItems) begin
         write_kind(phase < 4 ? kind_order[phase] : kind_type'($urandom_range(0, 3)));
         steady = (phase == 3);
         repeat ($urandom_range(2, 5)) queue_text(1'b1);
         // leave a text open so the next kind takes over mid-text
         if ($urandom_range(0, 3) == 0) queue_text(1'b0);
         drain();
         phase++;
      end
      steady = 1'b0;

      $display("covered %0d source bytes, %0d texts ended, %0d kind phases after %0d directed",
               accepted_count, texts_seen, phase, directed);
      $display("%0d result beats compared, %0d mismatches", beats_checked, errors);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
